// ===== src/nibble_complement_frame_decoder_top_macros.svh =====
// Assertion macros for the nibble complement frame decoder.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef NIBBLE_COMPLEMENT_FRAME_DECODER_TOP_MACROS_SVH
`define NIBBLE_COMPLEMENT_FRAME_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NCFD_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NCFD_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== src/ncfd_pkg.sv =====
// Package for the nibble complement frame decoder: widths, line symbols,
// event codes and the CRC-8 byte update. No dependencies.
package ncfd_pkg;

    localparam int LINE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int CRC_W   = 8;
    localparam int COUNT_W = 8;
    localparam int EVENT_W = 2;

    localparam logic [LINE_W-1:0]  SYM_STX           = 8'h02;
    localparam logic [LINE_W-1:0]  SYM_ETX           = 8'h03;
    localparam logic [CRC_W-1:0]   CRC_POLY          = 8'h8C;
    localparam logic [NIB_W-1:0]   NIB_MASK          = 4'hF;
    localparam logic [COUNT_W-1:0] MAX_PAYLOAD_RESET = 8'd100;

    typedef enum logic [EVENT_W-1:0] {
        EV_BYTE    = 2'd0,
        EV_ACCEPT  = 2'd1,
        EV_CRC_BAD = 2'd2,
        EV_ABORT   = 2'd3
    } event_t;

    // Reflected CRC-8, one data byte, LSB first.
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                  input logic [LINE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        crc = crc_in;
        for (int i = 0; i < LINE_W; i++)
        begin
            if (crc[0] ^ data[i])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

// ===== src/ncfd_if.sv =====
// Valid/ready channel interfaces for the line bytes and the result events.
// Depends on ncfd_pkg for the field widths.
interface ncfd_line_if
    import ncfd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [LINE_W-1:0] line_byte;

    modport source (output valid, output line_byte, input ready);
    modport sink   (input valid, input line_byte, output ready);
endinterface

interface ncfd_event_if
    import ncfd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;

    modport source (output valid, output event_res, input ready);
    modport sink   (input valid, input event_res, output ready);
endinterface

// ===== src/nibble_complement_frame_decoder_top.sv =====
// Path: a line byte taken from rx_in is held in the input register, decoded there, and its
// event is registered in the output register, from which it transfers on ev_out.
// Throughput: one line byte per cycle; the byte register and the output register
// both advance in the same cycle, so the input stalls only while a held event waits.
// Reset (rst_n, asynchronous, active low) clears the frame state and both valid flags
// and loads max_payload with 100.
//
// Depends on ncfd_pkg, the interfaces in ncfd_if.sv and the assertion macros header.
`include "nibble_complement_frame_decoder_top_macros.svh"

module nibble_complement_frame_decoder_top
    import ncfd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,
    ncfd_line_if.sink           rx_in,
    ncfd_event_if.source        ev_out
);

    // Configuration register: greatest payload length.
    logic [COUNT_W-1:0] max_payload_reg;

    // Input register stage. A received byte sits here while the frame logic
    // below decodes it against the current frame state.
    logic              s1_valid_reg;
    logic [LINE_W-1:0] s1_byte_reg;

    // Frame state.
    logic               in_frame_reg,    in_frame_next;
    logic               end_seen_reg,    end_seen_next;
    logic               expect_high_reg, expect_high_next;
    logic               frame_bad_reg,   frame_bad_next;
    logic [NIB_W-1:0]   high_nibble_reg, high_nibble_next;
    logic [COUNT_W-1:0] byte_count_reg,  byte_count_next;
    logic [CRC_W-1:0]   crc_reg,         crc_next;

    // Output register.
    logic   out_valid_reg;
    event_t out_event_reg;

    // Decode results for the byte in the input stage.
    logic             res_valid;
    event_t           res_event;
    logic [NIB_W-1:0] nib;
    logic             nib_ok;
    logic [LINE_W-1:0] full_byte;

    // The input stage hands its byte on when the output register is empty or its
    // event is transferring this cycle. A byte with no event still needs that
    // slot, which keeps the rule simple and costs nothing at full rate.
    logic s1_fire;

    assign s1_fire     = s1_valid_reg && (!out_valid_reg || ev_out.ready);
    assign rx_in.ready = !s1_valid_reg || s1_fire;

    assign ev_out.valid     = out_valid_reg;
    assign ev_out.event_res = out_event_reg;

    assign nib       = s1_byte_reg[LINE_W-1:NIB_W];
    assign nib_ok    = (nib == (s1_byte_reg[NIB_W-1:0] ^ NIB_MASK));
    assign full_byte = {high_nibble_reg, nib};

    // Frame decoding: start and end symbols first, then bytes outside a frame
    // are dropped, then the complement check, the nibble pairing, the CRC byte
    // after the end marker, and finally the payload length limit.
    always_comb
    begin
        in_frame_next    = in_frame_reg;
        end_seen_next    = end_seen_reg;
        expect_high_next = expect_high_reg;
        frame_bad_next   = frame_bad_reg;
        high_nibble_next = high_nibble_reg;
        byte_count_next  = byte_count_reg;
        crc_next         = crc_reg;
        res_valid        = 1'b0;
        res_event        = EV_BYTE;

        if (s1_byte_reg == SYM_STX)
        begin
            in_frame_next    = 1'b1;
            end_seen_next    = 1'b0;
            expect_high_next = 1'b1;
            frame_bad_next   = 1'b0;
            byte_count_next  = '0;
            crc_next         = '0;
        end
        else if (s1_byte_reg == SYM_ETX)
        begin
            // The end marker is recorded even outside a frame.
            end_seen_next = 1'b1;
        end
        else if (!in_frame_reg)
        begin
            // Idle line noise between frames.
        end
        else if (!nib_ok)
        begin
            frame_bad_next = 1'b1;
            in_frame_next  = 1'b0;
            res_valid      = 1'b1;
            res_event      = EV_ABORT;
        end
        else if (expect_high_reg)
        begin
            high_nibble_next = nib;
            expect_high_next = 1'b0;
        end
        else
        begin
            expect_high_next = 1'b1;
            res_valid        = 1'b1;
            if (end_seen_reg)
            begin
                // The first byte completed after the end marker is the CRC.
                in_frame_next = 1'b0;
                res_event     = (full_byte == crc_reg) ? EV_ACCEPT : EV_CRC_BAD;
            end
            else if (byte_count_reg < max_payload_reg)
            begin
                crc_next        = crc_feed(crc_reg, full_byte);
                byte_count_next = byte_count_reg + COUNT_W'(1);
                res_event       = EV_BYTE;
            end
            else
            begin
                frame_bad_next = 1'b1;
                in_frame_next  = 1'b0;
                res_event      = EV_ABORT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            max_payload_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx_in.ready)
        begin
            s1_valid_reg <= rx_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_in.valid && rx_in.ready)
        begin
            s1_byte_reg <= rx_in.line_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            end_seen_reg    <= 1'b0;
            expect_high_reg <= 1'b0;
            frame_bad_reg   <= 1'b0;
            high_nibble_reg <= '0;
            byte_count_reg  <= '0;
            crc_reg         <= '0;
        end
        else if (s1_fire)
        begin
            in_frame_reg    <= in_frame_next;
            end_seen_reg    <= end_seen_next;
            expect_high_reg <= expect_high_next;
            frame_bad_reg   <= frame_bad_next;
            high_nibble_reg <= high_nibble_next;
            byte_count_reg  <= byte_count_next;
            crc_reg         <= crc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= res_valid;
        end
        else if (ev_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && res_valid)
        begin
            out_event_reg <= res_event;
        end
    end

    // Any event other than a payload byte closes the frame.
    `NCFD_ASSERT_NEXT(a_frame_closes, s1_fire && res_valid && (res_event != EV_BYTE), !in_frame_reg, "frame still open after a closing event")

    // No payload byte is counted once the end marker has been seen.
    `NCFD_ASSERT_IMP(a_no_byte_after_end, s1_fire && res_valid && (res_event == EV_BYTE), !end_seen_reg, "payload byte decoded after end marker")

    // A start byte opens a fresh frame waiting for a high nibble.
    `NCFD_ASSERT_NEXT(a_start_opens, s1_fire && (s1_byte_reg == SYM_STX), in_frame_reg && expect_high_reg && (byte_count_reg == '0) && (crc_reg == '0), "start byte did not reset the frame")

    // An aborted frame is marked bad.
    `NCFD_ASSERT_NEXT(a_abort_marks_bad, s1_fire && res_valid && (res_event == EV_ABORT), frame_bad_reg, "abort without bad frame mark")

endmodule

// ===== bench/tb_nibble_complement_frame_decoder_top.sv =====
// Self-checking bench for nibble_complement_frame_decoder_top: a directed table of line
// bytes, then random framed traffic under several max_payload settings.
// Depends on ncfd_pkg, the channel interfaces in ncfd_if.sv and the decoder RTL.
module tb_nibble_complement_frame_decoder_top;

    import ncfd_pkg::*;

    // Run limits. The drain pause covers the input and output registers of the block plus margin,
    // so that a byte with no event has surely left the block before a register write.
    localparam int CLK_HALF     = 10;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 120;
    localparam int CYCLE_LIMIT  = 400000;

    // Directed table. A quiet row expects no event, an event row carries the event
    // that can be read straight off the framing rules, a predicted row leaves the
    // answer to the decoder model below, and a register row writes max_payload.
    typedef enum logic [1:0] {
        ROW_QUIET,
        ROW_EVENT,
        ROW_PREDICT,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [LINE_W-1:0] value;
        event_t            ev;
    } stim_row_t;

    localparam int DIRECTED_LEN = 30;

    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        // Bytes outside a frame give no event; an end marker among them is still recorded.
        '{ROW_QUIET,   SYM_ETX, EV_BYTE},
        '{ROW_QUIET,   8'hA5,   EV_BYTE},
        // One zero payload byte; the CRC of a single zero byte is zero.
        '{ROW_QUIET,   SYM_STX, EV_BYTE},
        '{ROW_QUIET,   8'h0F,   EV_BYTE},
        '{ROW_EVENT,   8'h0F,   EV_BYTE},
        '{ROW_QUIET,   SYM_ETX, EV_BYTE},
        '{ROW_QUIET,   8'h0F,   EV_BYTE},
        '{ROW_EVENT,   8'h0F,   EV_ACCEPT},
        // A start byte in the middle of a data byte restarts the frame.
        '{ROW_QUIET,   SYM_STX, EV_BYTE},
        '{ROW_QUIET,   8'hF0,   EV_BYTE},
        '{ROW_QUIET,   SYM_STX, EV_BYTE},
        '{ROW_QUIET,   8'hF0,   EV_BYTE},
        '{ROW_EVENT,   8'hF0,   EV_BYTE},
        // End marker between the two nibbles: the completed byte is the CRC.
        '{ROW_QUIET,   8'h87,   EV_BYTE},
        '{ROW_QUIET,   SYM_ETX, EV_BYTE},
        '{ROW_PREDICT, 8'h78,   EV_BYTE},
        // Complement failure on a high nibble, on a low nibble, and after the end.
        '{ROW_QUIET,   SYM_STX, EV_BYTE},
        '{ROW_EVENT,   8'h00,   EV_ABORT},
        '{ROW_QUIET,   SYM_STX, EV_BYTE},
        '{ROW_QUIET,   8'h5A,   EV_BYTE},
        '{ROW_EVENT,   8'hFF,   EV_ABORT},
        '{ROW_QUIET,   SYM_STX, EV_BYTE},
        '{ROW_QUIET,   SYM_ETX, EV_BYTE},
        '{ROW_EVENT,   8'h77,   EV_ABORT},
        // Payload limit of one: the second payload byte overflows.
        '{ROW_CFG,     8'd1,    EV_BYTE},
        '{ROW_QUIET,   SYM_STX, EV_BYTE},
        '{ROW_QUIET,   8'h0F,   EV_BYTE},
        '{ROW_EVENT,   8'h0F,   EV_BYTE},
        '{ROW_QUIET,   8'h0F,   EV_BYTE},
        '{ROW_EVENT,   8'h0F,   EV_ABORT}
    };

    // Decoder state as the bench tracks it, including its own copy of the register.
    typedef struct {
        logic               in_frame;
        logic               end_seen;
        logic               expect_high;
        logic               frame_bad;
        logic [NIB_W-1:0]   high_nib;
        logic [COUNT_W-1:0] byte_count;
        logic [CRC_W-1:0]   crc;
        logic [COUNT_W-1:0] max_payload;
    } decoder_state_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;

    ncfd_line_if  line_ch ();
    ncfd_event_if event_ch ();

    decoder_state_t line_state;
    event_t         expected_events [$];

    int idle_pct;
    int fail_count;
    int bytes_in_play;
    int cfg_writes;
    int cycle_count;
    int ev_tally [4];
    bit hold_request;

    nibble_complement_frame_decoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx_in     (line_ch),
        .ev_out    (event_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Reflected CRC-8 with polynomial 0x8C: the data byte is folded in at once and
    // then shifted out bit by bit, which matches feeding it LSB first.
    function automatic logic [CRC_W-1:0] crc8_maxim_update(input logic [CRC_W-1:0] crc_in,
                                                           input logic [LINE_W-1:0] data);
        logic [CRC_W-1:0] acc;
        acc = crc_in ^ data;
        repeat (LINE_W)
        begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    // A nibble on the line: the nibble in the high half, its complement in the low half.
    function automatic logic [LINE_W-1:0] nibble_line(input logic [NIB_W-1:0] nib);
        return {nib, ~nib};
    endfunction

    // Advances the tracked decoder state by one line byte. Returns 1 when the byte
    // produces an event and sets in_play to 0 when the decoder merely drops it.
    function automatic bit decode_line(input logic [LINE_W-1:0] b, output event_t ev,
                                       output bit in_play);
        logic [NIB_W-1:0]  nib;
        logic [LINE_W-1:0] full;
        ev      = EV_BYTE;
        in_play = 1'b1;
        if (b == SYM_STX)
        begin
            line_state.in_frame    = 1'b1;
            line_state.end_seen    = 1'b0;
            line_state.expect_high = 1'b1;
            line_state.frame_bad   = 1'b0;
            line_state.byte_count  = '0;
            line_state.crc         = '0;
            return 1'b0;
        end
        if (b == SYM_ETX)
        begin
            line_state.end_seen = 1'b1;
            return 1'b0;
        end
        if (!line_state.in_frame)
        begin
            in_play = 1'b0;
            return 1'b0;
        end
        nib = b[LINE_W-1:NIB_W];
        if (nib != (b[NIB_W-1:0] ^ NIB_MASK))
        begin
            line_state.frame_bad = 1'b1;
            line_state.in_frame  = 1'b0;
            ev = EV_ABORT;
            return 1'b1;
        end
        if (line_state.expect_high)
        begin
            line_state.high_nib    = nib;
            line_state.expect_high = 1'b0;
            return 1'b0;
        end
        full = {line_state.high_nib, nib};
        line_state.expect_high = 1'b1;
        if (line_state.end_seen)
        begin
            line_state.in_frame = 1'b0;
            ev = (full == line_state.crc) ? EV_ACCEPT : EV_CRC_BAD;
            return 1'b1;
        end
        if (line_state.byte_count < line_state.max_payload)
        begin
            line_state.crc        = crc8_maxim_update(line_state.crc, full);
            line_state.byte_count = line_state.byte_count + COUNT_W'(1);
            ev = EV_BYTE;
            return 1'b1;
        end
        line_state.frame_bad = 1'b1;
        line_state.in_frame  = 1'b0;
        ev = EV_ABORT;
        return 1'b1;
    endfunction

    // Offers one line byte after a random number of idle cycles and returns in the
    // time step of its transfer. Ready is sampled at the edge, so it is the value the
    // block held just before that edge.
    task automatic send_line(input logic [LINE_W-1:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            line_ch.valid <= 1'b0;
            @(posedge clk);
        end
        line_ch.valid     <= 1'b1;
        line_ch.line_byte <= b;
        @(posedge clk);
        while (!line_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_and_decode(input logic [LINE_W-1:0] b, output bit has_ev,
                                   output event_t ev, output bit in_play);
        send_line(b);
        has_ev = decode_line(b, ev, in_play);
    endtask

    // Register writes happen only once the block has gone quiet: every owed event
    // has arrived and the pipeline has had time to swallow any byte without an event.
    task automatic write_max_payload(input logic [COUNT_W-1:0] value);
        line_ch.valid <= 1'b0;
        while (expected_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        line_state.max_payload = value;
        cfg_writes++;
    endtask

    // Builds one frame: optional line noise, a start byte, a payload of random data,
    // the end marker and the CRC, which is usually right. A fraction of the frames is
    // damaged by a random byte or by an end marker at a random place.
    task automatic build_frame(input logic [COUNT_W-1:0] limit, ref logic [LINE_W-1:0] seq [$]);
        int               n;
        int               r;
        int               pos;
        logic [LINE_W-1:0] data;
        logic [CRC_W-1:0]  crc;
        seq.delete();
        if ($urandom_range(0, 99) < 25)
        begin
            repeat ($urandom_range(1, 3)) seq.push_back(LINE_W'($urandom_range(0, 255)));
        end
        r = $urandom_range(0, 9);
        if (r < 2 && limit <= 40)
        begin
            n = limit + r;
        end
        else
        begin
            n = $urandom_range(0, (limit < 8) ? limit + 1 : 8);
        end
        seq.push_back(SYM_STX);
        crc = '0;
        repeat (n)
        begin
            data = LINE_W'($urandom_range(0, 255));
            crc  = crc8_maxim_update(crc, data);
            seq.push_back(nibble_line(data[7:4]));
            seq.push_back(nibble_line(data[3:0]));
        end
        seq.push_back(SYM_ETX);
        if ($urandom_range(0, 99) >= 20)
        begin
            data = crc;
        end
        else
        begin
            data = LINE_W'($urandom_range(0, 255));
        end
        seq.push_back(nibble_line(data[7:4]));
        seq.push_back(nibble_line(data[3:0]));
        if ($urandom_range(0, 99) < 12)
        begin
            pos = $urandom_range(1, seq.size() - 1);
            seq[pos] = LINE_W'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 99) < 8)
        begin
            pos = $urandom_range(1, seq.size() - 1);
            seq.insert(pos, SYM_ETX);
        end
    endtask

    // One random phase under one payload limit. With with_hold set, the receiver is
    // asked halfway through to hold off for a long stretch while bytes keep coming.
    task automatic run_phase(input logic [COUNT_W-1:0] limit, input int n_items,
                             input int idle, input bit with_hold);
        logic [LINE_W-1:0] seq [$];
        int                target;
        bit                hold_done;
        bit                has_ev;
        bit                in_play;
        event_t            ev;
        write_max_payload(limit);
        idle_pct  = idle;
        target    = bytes_in_play + n_items;
        hold_done = 1'b0;
        while (bytes_in_play < target)
        begin
            build_frame(limit, seq);
            foreach (seq[k])
            begin
                send_and_decode(seq[k], has_ev, ev, in_play);
                if (has_ev)
                begin
                    expected_events.push_back(ev);
                end
                if (in_play)
                begin
                    bytes_in_play++;
                end
            end
            if (with_hold && !hold_done && bytes_in_play >= target - n_items / 2)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
        end
    endtask

    // Result side: checks each event transfer against the oldest owed event and
    // drives ready at random, or low for the whole of a requested hold-off.
    initial
    begin : result_side
        int     hold_left;
        event_t want;
        hold_left = 0;
        event_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (event_ch.valid && event_ch.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("event_res transfer with no event owed: actual %0d",
                           event_ch.event_res);
                    fail_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (event_ch.event_res !== want)
                    begin
                        $error("event_res mismatch: expected %s (%0d), actual %0d",
                               want.name(), want, event_ch.event_res);
                        fail_count++;
                    end
                    else
                    begin
                        ev_tally[want]++;
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                event_ch.ready <= 1'b0;
            end
            else
            begin
                event_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // Watchdog: a run that has not finished within the limit is a failure.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** nibble_complement_frame_decoder_top: FAILED **");
        $finish;
    end

    // Stimulus and the end of the run.
    initial
    begin : stimulus
        stim_row_t row;
        bit        has_ev;
        bit        in_play;
        event_t    ev;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        line_ch.valid     <= 1'b0;
        line_ch.line_byte <= '0;
        idle_pct      = 31;
        fail_count    = 0;
        bytes_in_play = 0;
        cfg_writes    = 0;
        hold_request  = 1'b0;
        foreach (ev_tally[k])
        begin
            ev_tally[k] = 0;
        end

        // The tracked state starts where reset leaves the block.
        line_state.in_frame    = 1'b0;
        line_state.end_seen    = 1'b0;
        line_state.expect_high = 1'b0;
        line_state.frame_bad   = 1'b0;
        line_state.high_nib    = '0;
        line_state.byte_count  = '0;
        line_state.crc         = '0;
        line_state.max_payload = MAX_PAYLOAD_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Typed rows put their own event in the queue; the tracked
        // state still advances on every byte so the random part starts in step.
        for (int i = 0; i < DIRECTED_LEN; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_CFG)
            begin
                write_max_payload(row.value);
            end
            else
            begin
                send_and_decode(row.value, has_ev, ev, in_play);
                if (row.kind == ROW_EVENT)
                begin
                    expected_events.push_back(row.ev);
                end
                else if (row.kind == ROW_PREDICT && has_ev)
                begin
                    expected_events.push_back(ev);
                end
                if (in_play)
                begin
                    bytes_in_play++;
                end
            end
        end

        // Random phases. The largest limit carries the long receiver hold-off; the
        // phase at limit 2 runs with no idling on either side. Each phase starts with
        // a register write, so the sender first waits for every owed event.
        run_phase(8'd255, 130, 31, 1'b1);
        run_phase(MAX_PAYLOAD_RESET, 110, 31, 1'b0);
        run_phase(8'd2, 110, 0, 1'b0);
        run_phase(8'd1, 90, 31, 1'b0);
        run_phase(COUNT_W'($urandom_range(3, 60)), 130, 31, 1'b0);
        run_phase(COUNT_W'($urandom_range(1, 255)), 100, 31, 1'b0);

        line_ch.valid <= 1'b0;
        while (expected_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_events.size() != 0)
        begin
            $error("%0d events still owed at the end of the run", expected_events.size());
            fail_count++;
        end

        $display("Run covered %0d framed line bytes over %0d max_payload settings in %0d cycles.",
                 bytes_in_play, cfg_writes, cycle_count);
        $display("Events checked: %0d payload, %0d accepted, %0d checksum rejects, %0d aborts.",
                 ev_tally[EV_BYTE], ev_tally[EV_ACCEPT], ev_tally[EV_CRC_BAD],
                 ev_tally[EV_ABORT]);
        if (fail_count == 0)
        begin
            $display("** nibble_complement_frame_decoder_top: PASSED **");
        end
        else
        begin
            $display("** nibble_complement_frame_decoder_top: FAILED **");
        end
        $finish;
    end

endmodule
